// ===== sv/assert_macros.svh =====
// Assertion macros shared by the speed limiter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is high.
`define ASSERT_CHK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check that also holds while reset is high.
`define ASSERT_CHK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_CHK(lbl, clk, rst, prop)
`define ASSERT_CHK_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/mwsl_pkg.sv =====
// Types and constants of the mecanum wheel speed limiter.
// Used by mwsl_div_stage, mecanum_wheel_speed_limiter_core and its testbench; no dependencies.
package mwsl_pkg;

   localparam int LANES          = 4;
   localparam int VEL_W          = 8;
   localparam int SUM_W          = 10;
   localparam int MAG_W          = 9;
   localparam int GAIN_W         = 10;
   localparam int LIMIT_W        = 7;
   localparam int FRAC_W         = 8;
   localparam int PROD_W         = MAG_W + GAIN_W;
   localparam int NUM_W          = PROD_W + LIMIT_W;
   localparam int DVD_W          = NUM_W - FRAC_W;
   localparam int QUO_W          = 9;
   localparam int UNL_W          = PROD_W - FRAC_W;
   localparam int WHEEL_W        = 8;
   localparam int BITS_PER_STAGE = 3;
   localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd307;
   localparam logic [UNL_W-1:0]  SAT_POS    = 11'd127;
   localparam logic [UNL_W-1:0]  SAT_NEG    = 11'd128;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_rot;
      logic                    target_valid;
      logic                    car_running;
      logic [LIMIT_W-1:0]      speed_limit;
   } mwsl_req_type;

   typedef struct packed {
      logic signed [WHEEL_W-1:0] wheel_front_left;
      logic signed [WHEEL_W-1:0] wheel_front_right;
      logic signed [WHEEL_W-1:0] wheel_rear_left;
      logic signed [WHEEL_W-1:0] wheel_rear_right;
   } mwsl_rsp_type;

   // One wheel inside the divider: partial remainder, and a word that holds the
   // unused dividend bits on the left and the quotient bits shifted in on the right.
   typedef struct packed {
      logic             neg;
      logic [UNL_W-1:0] unl;
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] acc;
   } mwsl_lane_type;

   typedef struct packed {
      logic                           en;
      logic                           limited;
      logic [MAG_W-1:0]               div;
      mwsl_lane_type [LANES-1:0]      lane;
   } mwsl_stage_type;

endpackage

// ===== sv/mwsl_div_stage.sv =====
// One registered stage of the restoring divider, three quotient bits for all four wheels.
// Depends on mwsl_pkg.
module mwsl_div_stage import mwsl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  mwsl_stage_type in_stage,
   output logic           out_valid,
   output mwsl_stage_type out_stage
);

   logic           valid_ff;
   logic           valid_in;
   mwsl_stage_type stage_ff;
   mwsl_stage_type stage_in;

   assign valid_in = in_valid;

   always_comb begin
      logic [MAG_W:0] trial;
      logic           bit_q;
      stage_in = in_stage;
      for (int l = 0; l < LANES; l++) begin
         for (int k = 0; k < BITS_PER_STAGE; k++) begin
            trial = {stage_in.lane[l].rem, stage_in.lane[l].acc[QUO_W-1]};
            bit_q = (trial >= {1'b0, in_stage.div});
            if (bit_q) begin
               stage_in.lane[l].rem = MAG_W'(trial - {1'b0, in_stage.div});
            end else begin
               stage_in.lane[l].rem = trial[MAG_W-1:0];
            end
            stage_in.lane[l].acc = {stage_in.lane[l].acc[QUO_W-2:0], bit_q};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== sv/mecanum_wheel_speed_limiter_core.sv =====
// Mecanum wheel speed limiter: body velocity command to four limited wheel commands.
// Depends on mwsl_pkg, mwsl_div_stage and assert_macros.svh.
//
// Usage
//   A command is taken at each rising edge where start is high and busy is low.
//   busy is high only during reset, so a new command may be given in every cycle.
//   Each command gives exactly one result on rsp_payload, shown for one cycle with
//   rsp_strobe high.
//   Throughput is one command per cycle; the latency is set by the pipeline:
//   sums, maximum and gain product, limit product, three divider stages of three
//   quotient bits each, and the saturating output register.
//   The receiver cannot hold results off, so nothing in the pipeline ever stalls.
//   The gain register is written through csr_valid/csr_ready/csr_data; csr_ready
//   is high only while no command is offered or in flight.
//   Reset (synchronous, active high) empties the pipeline and sets the gain to
//   307, about 1.2 in unsigned Q2.8.
//   A command that is not valid, or given while the car is not running, gives
//   four zero wheel commands.
module mecanum_wheel_speed_limiter_core import mwsl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mwsl_req_type        req_payload,
   output logic                rsp_strobe,
   output mwsl_rsp_type        rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [GAIN_W-1:0]   csr_data
);

   `include "assert_macros.svh"

   // Gain register.
   logic [GAIN_W-1:0] gain_ff;
   logic [GAIN_W-1:0] gain_in;

   // Stage 1: wheel sums.
   logic                    v1_ff;
   logic                    v1_in;
   logic                    en1_ff;
   logic [LIMIT_W-1:0]      lim1_ff;
   logic signed [SUM_W-1:0] sum1_ff [LANES];
   logic signed [SUM_W-1:0] sum1_in [LANES];
   logic signed [SUM_W-1:0] vx_ext;
   logic signed [SUM_W-1:0] vy_ext;
   logic signed [SUM_W-1:0] vr_ext;

   // Stage 2: largest magnitude, limit decision and gain product.
   logic               v2_ff;
   logic               en2_ff;
   logic               limited2_ff;
   logic [LIMIT_W-1:0] lim2_ff;
   logic [MAG_W-1:0]   max2_ff;
   logic [LANES-1:0]   neg2_ff;
   logic [PROD_W-1:0]  mg2_ff [LANES];
   logic [MAG_W-1:0]   mag_w [LANES];
   logic [PROD_W-1:0]  mg_w [LANES];
   logic [MAG_W-1:0]   max01_w;
   logic [MAG_W-1:0]   max23_w;
   logic [MAG_W-1:0]   max_w;

   // Stage 3: limit product, divider set-up.
   logic           v3_ff;
   mwsl_stage_type s3_ff;
   mwsl_stage_type s3_in;
   logic [NUM_W-1:0] num_w [LANES];

   // Divider pipeline: index 0 is stage 3, index DIV_STAGES is the last stage.
   logic           div_valid [DIV_STAGES+1];
   mwsl_stage_type div_stage [DIV_STAGES+1];
   logic           tail_v;
   logic           tail_lim;
   mwsl_stage_type tail;

   // Output register.
   logic         rsp_strobe_ff;
   logic         rsp_strobe_in;
   mwsl_rsp_type rsp_data_ff;
   mwsl_rsp_type rsp_data_in;
   logic [WHEEL_W-1:0] wheel_w [LANES];

   assign busy  = reset;
   assign v1_in = start && !busy;

   assign gain_in = (csr_valid && csr_ready) ? csr_data : gain_ff;

   // The pipeline must be empty, with no command offered, before the gain may change.
   assign csr_ready = !(start || v1_ff || v2_ff || v3_ff || div_valid[1] || div_valid[2]
                        || div_valid[DIV_STAGES] || rsp_strobe_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // ---------------- stage 1 ----------------
   assign vx_ext = SUM_W'(req_payload.vel_x);
   assign vy_ext = SUM_W'(req_payload.vel_y);
   assign vr_ext = SUM_W'(req_payload.vel_rot);

   assign sum1_in[0] = -vx_ext - vy_ext + vr_ext;
   assign sum1_in[1] = -vx_ext + vy_ext + vr_ext;
   assign sum1_in[2] =  vx_ext - vy_ext + vr_ext;
   assign sum1_in[3] =  vx_ext + vy_ext + vr_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      en1_ff  <= req_payload.target_valid && req_payload.car_running;
      lim1_ff <= req_payload.speed_limit;
      for (int l = 0; l < LANES; l++) begin
         sum1_ff[l] <= sum1_in[l];
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mag_w[l] = sum1_ff[l][SUM_W-1] ? MAG_W'(-sum1_ff[l]) : MAG_W'(sum1_ff[l]);
         mg_w[l]  = PROD_W'(mag_w[l]) * PROD_W'(gain_ff);
      end
   end

   assign max01_w = (mag_w[0] > mag_w[1]) ? mag_w[0] : mag_w[1];
   assign max23_w = (mag_w[2] > mag_w[3]) ? mag_w[2] : mag_w[3];
   assign max_w   = (max01_w > max23_w) ? max01_w : max23_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      en2_ff      <= en1_ff;
      lim2_ff     <= lim1_ff;
      max2_ff     <= max_w;
      limited2_ff <= (max_w > MAG_W'(lim1_ff));
      for (int l = 0; l < LANES; l++) begin
         neg2_ff[l] <= sum1_ff[l][SUM_W-1];
         mg2_ff[l]  <= mg_w[l];
      end
   end

   // ---------------- stage 3 ----------------
   // The limited quotient is floor(floor(m*g*limit/256) / max); the top
   // dividend bits start the remainder, which stays below the divisor as the
   // quotient never reaches 512.
   always_comb begin
      s3_in.en      = en2_ff;
      s3_in.limited = limited2_ff;
      s3_in.div     = max2_ff;
      for (int l = 0; l < LANES; l++) begin
         num_w[l]          = NUM_W'(mg2_ff[l]) * NUM_W'(lim2_ff);
         s3_in.lane[l].neg = neg2_ff[l];
         s3_in.lane[l].unl = mg2_ff[l][PROD_W-1:FRAC_W];
         s3_in.lane[l].rem = num_w[l][NUM_W-1:NUM_W-MAG_W];
         s3_in.lane[l].acc = num_w[l][FRAC_W+QUO_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_ff <= s3_in;
   end

   assign div_valid[0] = v3_ff;
   assign div_stage[0] = s3_ff;

   // ---------------- divider ----------------
   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      mwsl_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[d]),
         .in_stage  (div_stage[d]),
         .out_valid (div_valid[d+1]),
         .out_stage (div_stage[d+1])
      );
   end

   assign tail_v   = div_valid[DIV_STAGES];
   assign tail     = div_stage[DIV_STAGES];
   assign tail_lim = tail_v && tail.limited;

   // ---------------- saturation and output ----------------
   always_comb begin
      logic [UNL_W-1:0] q;
      for (int l = 0; l < LANES; l++) begin
         q = tail.limited ? UNL_W'(tail.lane[l].acc) : tail.lane[l].unl;
         if (!tail.en) begin
            wheel_w[l] = '0;
         end else if (tail.lane[l].neg) begin
            wheel_w[l] = (q > SAT_NEG) ? SAT_NEG[WHEEL_W-1:0] : WHEEL_W'(UNL_W'(0) - q);
         end else begin
            wheel_w[l] = (q > SAT_POS) ? SAT_POS[WHEEL_W-1:0] : q[WHEEL_W-1:0];
         end
      end
   end

   assign rsp_strobe_in                 = tail_v;
   assign rsp_data_in.wheel_front_left  = wheel_w[0];
   assign rsp_data_in.wheel_front_right = wheel_w[1];
   assign rsp_data_in.wheel_rear_left   = wheel_w[2];
   assign rsp_data_in.wheel_rear_right  = wheel_w[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------- checks ----------------
   `ASSERT_CHK_ALWAYS(a_reset_empties, clock, reset |=> !rsp_strobe && csr_ready)
   `ASSERT_CHK(a_div_nonzero, clock, reset, v3_ff && s3_ff.limited |-> s3_ff.div != '0)
   `ASSERT_CHK(a_disabled_zero, clock, reset, tail_v && !tail.en |=> rsp_strobe && rsp_payload == '0)

   for (genvar c = 0; c < LANES; c++) begin : g_chk
      logic [UNL_W-1:0] quo_c;
      assign quo_c = UNL_W'(tail.lane[c].acc);
      `ASSERT_CHK(a_rem_below_div, clock, reset, tail_lim |-> tail.lane[c].rem < tail.div)
      `ASSERT_CHK(a_limit_shrinks, clock, reset, tail_lim |-> quo_c <= tail.lane[c].unl)
   end

endmodule

// ===== tb/mecanum_wheel_speed_limiter_core_tb.sv =====
// Self-checking testbench for mecanum_wheel_speed_limiter_core: directed and random commands
// over several gain settings, checked against an in-bench wheel speed predictor.
// Depends on mwsl_pkg and the core RTL only.
module mecanum_wheel_speed_limiter_core_tb import mwsl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int IDLE_PERCENT  = 12;
   localparam int REPORT_LIMIT  = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   mwsl_req_type        req_payload = '0;
   logic                rsp_strobe;
   mwsl_rsp_type        rsp_payload;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [GAIN_W-1:0]   csr_data = '0;

   mwsl_req_type        command_q[$];
   mwsl_rsp_type        wheel_expect_q[$];
   logic [GAIN_W-1:0]   gain_setting = GAIN_RESET;
   bit                  sender_idles = 1'b1;
   int unsigned         commands_taken = 0;
   int unsigned         results_seen = 0;
   int unsigned         gain_writes = 0;
   int unsigned         fault_count = 0;
   int unsigned         cycles = 0;

   mecanum_wheel_speed_limiter_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Expected wheel commands for one body velocity command at the given gain.
   function automatic mwsl_rsp_type wheel_targets(mwsl_req_type cmd, logic [GAIN_W-1:0] gain);
      longint       sum [LANES];
      longint       wheel [LANES];
      longint       vx, vy, rot, lim, g, peak, m, num, den, q;
      mwsl_rsp_type res;
      res = '0;
      if (!(cmd.target_valid && cmd.car_running)) begin
         return res;
      end
      vx   = longint'($signed(cmd.vel_x));
      vy   = longint'($signed(cmd.vel_y));
      rot  = longint'($signed(cmd.vel_rot));
      lim  = longint'(cmd.speed_limit);
      g    = longint'(gain);
      sum[0] = -vx - vy + rot;
      sum[1] = -vx + vy + rot;
      sum[2] =  vx - vy + rot;
      sum[3] =  vx + vy + rot;
      peak = 0;
      for (int k = 0; k < LANES; k++) begin
         m = (sum[k] < 0) ? -sum[k] : sum[k];
         if (m > peak) peak = m;
      end
      for (int k = 0; k < LANES; k++) begin
         m = (sum[k] < 0) ? -sum[k] : sum[k];
         // Limiting only applies when the largest wheel exceeds the allowed speed.
         if (g > 0 && peak > lim) begin
            num = m * g * lim;
            den = peak * 256;
         end else begin
            num = m * g;
            den = 256;
         end
         q = num / den;
         if (sum[k] < 0) wheel[k] = (q > 128) ? -128 : -q;
         else            wheel[k] = (q > 127) ? 127 : q;
      end
      res.wheel_front_left  = wheel[0][WHEEL_W-1:0];
      res.wheel_front_right = wheel[1][WHEEL_W-1:0];
      res.wheel_rear_left   = wheel[2][WHEEL_W-1:0];
      res.wheel_rear_right  = wheel[3][WHEEL_W-1:0];
      return res;
   endfunction

   function automatic mwsl_req_type make_command(int vx, int vy, int rot, bit valid, bit running,
                                                 int lim);
      mwsl_req_type cmd;
      cmd.vel_x        = vx[VEL_W-1:0];
      cmd.vel_y        = vy[VEL_W-1:0];
      cmd.vel_rot      = rot[VEL_W-1:0];
      cmd.target_valid = valid;
      cmd.car_running  = running;
      cmd.speed_limit  = lim[LIMIT_W-1:0];
      return cmd;
   endfunction

   // Fully random payload bits.
   function automatic mwsl_req_type random_noise();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return mwsl_req_type'(noise[$bits(mwsl_req_type)-1:0]);
   endfunction

   // Mostly valid commands for a running car, with small speeds now and then so that the
   // unlimited path is reached as well as the limited one.
   function automatic mwsl_req_type random_command();
      mwsl_req_type cmd;
      int           span;
      cmd = random_noise();
      if ($urandom_range(99) < 30) begin
         span = $urandom_range(40, 1);
         cmd.vel_x   = VEL_W'($urandom_range(2 * span) - span);
         cmd.vel_y   = VEL_W'($urandom_range(2 * span) - span);
         cmd.vel_rot = VEL_W'($urandom_range(2 * span) - span);
      end
      if ($urandom_range(99) < 85) begin
         cmd.target_valid = 1'b1;
         cmd.car_running  = 1'b1;
      end
      if ($urandom_range(99) < 70) cmd.speed_limit = LIMIT_W'($urandom_range(100));
      return cmd;
   endfunction

   task automatic note_failure(string what);
      if (fault_count < REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
      fault_count++;
   endtask

   // Sender: one command per transfer, with random gaps when enabled. The payload carries
   // junk while start is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            wheel_expect_q.push_back(wheel_targets(req_payload, gain_setting));
            commands_taken++;
         end
         if (!start || !busy) begin
            if (command_q.size() == 0 ||
                (sender_idles && $urandom_range(99) < IDLE_PERCENT)) begin
               start       <= 1'b0;
               req_payload <= random_noise();
            end else begin
               start       <= 1'b1;
               req_payload <= command_q.pop_front();
            end
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      mwsl_rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (wheel_expect_q.size() == 0) begin
            note_failure($sformatf("unexpected result %h", rsp_payload));
         end else begin
            want = wheel_expect_q.pop_front();
            if (rsp_payload.wheel_front_left !== want.wheel_front_left)
               note_failure($sformatf("front left: expected %0d, got %0d",
                  want.wheel_front_left, rsp_payload.wheel_front_left));
            if (rsp_payload.wheel_front_right !== want.wheel_front_right)
               note_failure($sformatf("front right: expected %0d, got %0d",
                  want.wheel_front_right, rsp_payload.wheel_front_right));
            if (rsp_payload.wheel_rear_left !== want.wheel_rear_left)
               note_failure($sformatf("rear left: expected %0d, got %0d",
                  want.wheel_rear_left, rsp_payload.wheel_rear_left));
            if (rsp_payload.wheel_rear_right !== want.wheel_rear_right)
               note_failure($sformatf("rear right: expected %0d, got %0d",
                  want.wheel_rear_right, rsp_payload.wheel_rear_right));
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Queue updates and the drain test happen on the falling edge, clear of the sender.
   task automatic wait_drained();
      do @(negedge clock);
      while (command_q.size() != 0 || start || wheel_expect_q.size() != 0);
   endtask

   task automatic write_gain(logic [GAIN_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      gain_setting = value;
      gain_writes++;
      csr_valid <= 1'b0;
      csr_data  <= GAIN_W'($urandom);
      @(negedge clock);
   endtask

   task automatic load_directed();
      command_q.push_back(make_command(   0,    0,    0, 1, 1,   0));
      command_q.push_back(make_command( 127,  127,  127, 1, 1, 127));
      command_q.push_back(make_command(-128, -128, -128, 1, 1, 127));
      command_q.push_back(make_command( 127, -128,  127, 1, 1, 100));
      command_q.push_back(make_command(-128,  127, -128, 1, 1, 100));
      command_q.push_back(make_command( 127,  127,  127, 0, 1, 100));
      command_q.push_back(make_command( 127,  127,  127, 1, 0, 100));
      command_q.push_back(make_command(-128, -128, -128, 0, 0, 127));
      command_q.push_back(make_command(  50,  -30,   20, 1, 1,   0));
      command_q.push_back(make_command(  10,    5,   -3, 1, 1, 100));
      command_q.push_back(make_command( 100,    0,    0, 1, 1, 127));
      command_q.push_back(make_command(-100,    0,    0, 1, 1, 127));
      command_q.push_back(make_command(   0,    0, -128, 1, 1, 127));
      command_q.push_back(make_command(   0,  127,    0, 1, 1,   1));
      command_q.push_back(make_command(   1,    0,    0, 1, 1,   0));
      command_q.push_back(make_command(  -1,   -1,   -1, 1, 1,   3));
      command_q.push_back(make_command(  64,   64,    0, 1, 1,  50));
      command_q.push_back(make_command(-128,    0,    0, 1, 1, 127));
      command_q.push_back(make_command( 127,    0,    0, 1, 1, 127));
      command_q.push_back(make_command(   0,    0,    0, 0, 0,   0));
   endtask

   task automatic load_random(int count);
      for (int k = 0; k < count; k++) command_q.push_back(random_command());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset gain first, then the extremes of the gain register.
      load_directed();
      load_random(60);
      wait_drained();

      write_gain('1);
      load_directed();
      load_random(140);
      wait_drained();

      write_gain('0);
      load_directed();
      load_random(80);
      wait_drained();

      // A long stretch with the sender never idling.
      sender_idles = 1'b0;
      write_gain(10'd256);
      load_random(200);
      wait_drained();
      sender_idles = 1'b1;

      write_gain(10'd1);
      load_random(80);
      wait_drained();

      write_gain(GAIN_W'($urandom_range(1023, 1)));
      load_random(150);
      wait_drained();

      write_gain(GAIN_RESET);
      load_random(130);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (wheel_expect_q.size() != 0)
         note_failure($sformatf("%0d results never arrived", wheel_expect_q.size()));

      $display("Covered %0d commands and %0d results over %0d gain writes.",
               commands_taken, results_seen, gain_writes);
      $display("Failures counted: %0d", fault_count);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
